FILE: design/rtf_pkg.sv
package rtf_pkg;

   localparam int TABLE_SIZE = 32;
   localparam int KEY_W = 16;
   localparam int HASH_ROT = 3;   // low key bits rotated to the top of the index

   localparam logic [1:0] KIND_ENABLE = 2'd0;
   localparam logic [1:0] KIND_DISABLE = 2'd1;
   localparam logic [1:0] KIND_FORCE_ENABLE = 2'd2;
   localparam logic [1:0] KIND_FORCE_DISABLE = 2'd3;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_ZERO = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      STATE_CLEAR,
      STATE_IDLE,
      STATE_LOOK
   } state_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic [KEY_W-1:0] cap;
   } req_type;

   typedef struct packed {
      logic       issue_call;
      logic       call_enable;
      status_type status;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             value;
   } entry_type;

   typedef struct packed {
      logic      rd_en;
      logic      wr_en;
      entry_type wr_data;
   } mem_cmd_type;

endpackage

FILE: design/rtf_table.sv
module rtf_table #(
   parameter int TABLE_SIZE = rtf_pkg::TABLE_SIZE,
   parameter int ADDR_W = $clog2(TABLE_SIZE)
) (
   input  logic                 clock,
   input  rtf_pkg::mem_cmd_type cmd,
   input  logic [ADDR_W-1:0]    rd_addr,
   input  logic [ADDR_W-1:0]    wr_addr,
   output rtf_pkg::entry_type   rd_data
);

   rtf_pkg::entry_type mem [TABLE_SIZE];
   rtf_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/rtf_ctrl.sv
module rtf_ctrl #(
   parameter int TABLE_SIZE = rtf_pkg::TABLE_SIZE,
   parameter int ADDR_W = $clog2(TABLE_SIZE)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  rtf_pkg::req_type     req_item,
   output logic                 strobe,
   output rtf_pkg::rsp_type     rsp_item,
   output rtf_pkg::mem_cmd_type cmd,
   output logic [ADDR_W-1:0]    rd_addr,
   output logic [ADDR_W-1:0]    wr_addr,
   input  rtf_pkg::entry_type   rd_data
);

   localparam logic [ADDR_W-1:0] LAST = ADDR_W'(TABLE_SIZE - 1);

   rtf_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [ADDR_W-1:0]  count_ff, count_in;
   rtf_pkg::req_type   item_ff, item_in;
   rtf_pkg::rsp_type   rsp_ff, rsp_in;
   logic               strobe_ff, strobe_in;

   logic [ADDR_W-1:0] home;
   logic              want, forced;
   logic              hit, empty, full;

   // rotate: low three index bits of the key move to the top
   assign home = {req_item.cap[rtf_pkg::HASH_ROT-1:0],
                  req_item.cap[ADDR_W-1:rtf_pkg::HASH_ROT]};

   always_comb begin
      unique case (item_ff.kind)
         rtf_pkg::KIND_ENABLE:        begin want = 1'b1; forced = 1'b0; end
         rtf_pkg::KIND_DISABLE:       begin want = 1'b0; forced = 1'b0; end
         rtf_pkg::KIND_FORCE_ENABLE:  begin want = 1'b1; forced = 1'b1; end
         rtf_pkg::KIND_FORCE_DISABLE: begin want = 1'b0; forced = 1'b1; end
         default:                     begin want = 1'b0; forced = 1'b0; end
      endcase
   end

   assign hit   = (rd_data.key == item_ff.cap);
   assign empty = (rd_data.key == '0);
   assign full  = (count_ff == LAST);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rtf_pkg::STATE_CLEAR: if (idx_ff == LAST) state_in = rtf_pkg::STATE_IDLE;
         rtf_pkg::STATE_IDLE: begin
            if (start && req_item.cap != '0) state_in = rtf_pkg::STATE_LOOK;
         end
         rtf_pkg::STATE_LOOK: if (hit || empty) state_in = rtf_pkg::STATE_IDLE;
         default: state_in = rtf_pkg::STATE_CLEAR;
      endcase
   end

   // outputs and datapath
   always_comb begin
      busy = 1'b1;
      cmd = '0;
      rd_addr = idx_ff;
      wr_addr = idx_ff;
      idx_in = idx_ff;
      count_in = count_ff;
      item_in = item_ff;
      rsp_in = rsp_ff;
      strobe_in = 1'b0;
      unique case (state_ff)
         rtf_pkg::STATE_CLEAR: begin
            cmd.wr_en = 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         rtf_pkg::STATE_IDLE: begin
            busy = 1'b0;
            if (start) begin
               item_in = req_item;
               if (req_item.cap == '0) begin
                  strobe_in = 1'b1;
                  rsp_in.issue_call = 1'b0;
                  rsp_in.call_enable = 1'b0;
                  rsp_in.status = rtf_pkg::STATUS_ZERO;
               end else begin
                  cmd.rd_en = 1'b1;
                  rd_addr = home;
                  idx_in = home;
               end
            end
         end
         rtf_pkg::STATE_LOOK: begin
            if (hit) begin
               cmd.wr_en = 1'b1;
               cmd.wr_data.key = item_ff.cap;
               cmd.wr_data.value = want;
               strobe_in = 1'b1;
               rsp_in.issue_call = forced || (rd_data.value != want);
               rsp_in.call_enable = (forced || (rd_data.value != want)) && want;
               rsp_in.status = rtf_pkg::STATUS_OK;
            end else if (empty) begin
               strobe_in = 1'b1;
               rsp_in.issue_call = 1'b1;
               rsp_in.call_enable = want;
               if (full) begin
                  rsp_in.status = rtf_pkg::STATUS_FULL;
               end else begin
                  cmd.wr_en = 1'b1;
                  cmd.wr_data.key = item_ff.cap;
                  cmd.wr_data.value = want;
                  count_in = count_ff + 1'b1;
                  rsp_in.status = rtf_pkg::STATUS_OK;
               end
            end else begin
               // occupied by another key: step to the next slot, wrapping
               cmd.rd_en = 1'b1;
               rd_addr = idx_ff + 1'b1;
               idx_in = idx_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtf_pkg::STATE_CLEAR;
         idx_ff <= '0;
         count_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         count_ff <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff <= rsp_in;
   end

   assign strobe = strobe_ff;
   assign rsp_item = rsp_ff;

endmodule

FILE: design/redundant_toggle_filter_core.sv
// channel   ports                          handshake
// request   start, busy, req_item          accepted when start && !busy
// response  strobe, rsp_item               valid for one cycle while strobe is high
//
// An item with a nonzero key is answered after a read of its home slot and one more read
// for each occupied slot stepped over on the probe path; the single-port-read table serves
// one read per cycle. A zero key is answered in the cycle after it is accepted.
// After reset a clearing pass writes every slot, with busy high.
// The response cannot be stalled; busy drops again in the cycle the strobe is shown.
module redundant_toggle_filter_core #(
   parameter int TABLE_SIZE = rtf_pkg::TABLE_SIZE
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rtf_pkg::req_type req_item,
   output logic             strobe,
   output rtf_pkg::rsp_type rsp_item
);

   localparam int ADDR_W = $clog2(TABLE_SIZE);

   rtf_pkg::mem_cmd_type cmd;
   logic [ADDR_W-1:0]    rd_addr, wr_addr;
   rtf_pkg::entry_type   rd_data;

   rtf_ctrl #(
      .TABLE_SIZE(TABLE_SIZE),
      .ADDR_W(ADDR_W)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .strobe(strobe),
      .rsp_item(rsp_item),
      .cmd(cmd),
      .rd_addr(rd_addr),
      .wr_addr(wr_addr),
      .rd_data(rd_data)
   );

   rtf_table #(
      .TABLE_SIZE(TABLE_SIZE),
      .ADDR_W(ADDR_W)
   ) u_table (
      .clock(clock),
      .cmd(cmd),
      .rd_addr(rd_addr),
      .wr_addr(wr_addr),
      .rd_data(rd_data)
   );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

class toggle_filter_model;
   logic [rtf_pkg::KEY_W-1:0] key_tab [rtf_pkg::TABLE_SIZE];
   logic                      val_tab [rtf_pkg::TABLE_SIZE];
   int                        fill;
   rtf_pkg::rsp_type          expected_rsp [$];
   int                        errors;
   int                        checked;
   int                        n_forward;
   int                        n_redundant;
   int                        n_full;
   int                        n_zero;

   function new();
      foreach (key_tab[i]) begin
         key_tab[i] = '0;
         val_tab[i] = 1'b0;
      end
      fill = 0;
      errors = 0;
      checked = 0;
      n_forward = 0;
      n_redundant = 0;
      n_full = 0;
      n_zero = 0;
   endfunction

   // low HASH_ROT bits of the masked key go to the top of the index
   function int home_slot(logic [rtf_pkg::KEY_W-1:0] cap);
      int k;
      int low_mask;
      low_mask = (1 << rtf_pkg::HASH_ROT) - 1;
      k = int'(cap) & (rtf_pkg::TABLE_SIZE - 1);
      return ((k & low_mask) * (rtf_pkg::TABLE_SIZE >> rtf_pkg::HASH_ROT))
             | (k >> rtf_pkg::HASH_ROT);
   endfunction

   function int find_slot(logic [rtf_pkg::KEY_W-1:0] cap);
      int i;
      i = home_slot(cap) & (rtf_pkg::TABLE_SIZE - 1);
      for (int n = 0; n < rtf_pkg::TABLE_SIZE; n++) begin
         if (key_tab[i] == '0 || key_tab[i] == cap) break;
         i = (i + 1) & (rtf_pkg::TABLE_SIZE - 1);
      end
      return i;
   endfunction

   function void note_request(rtf_pkg::req_type req);
      rtf_pkg::rsp_type exp;
      logic             want;
      logic             forced;
      int               slot;
      want = (req.kind == rtf_pkg::KIND_ENABLE || req.kind == rtf_pkg::KIND_FORCE_ENABLE);
      forced = (req.kind == rtf_pkg::KIND_FORCE_ENABLE ||
                req.kind == rtf_pkg::KIND_FORCE_DISABLE);
      exp.issue_call = 1'b0;
      exp.call_enable = 1'b0;
      exp.status = rtf_pkg::STATUS_OK;
      if (req.cap == '0) begin
         exp.status = rtf_pkg::STATUS_ZERO;
         n_zero++;
      end else begin
         slot = find_slot(req.cap);
         if (key_tab[slot] == req.cap) begin
            if (forced || val_tab[slot] != want) begin
               exp.issue_call = 1'b1;
               exp.call_enable = want;
            end else begin
               n_redundant++;
            end
            val_tab[slot] = want;
         end else if (fill >= rtf_pkg::TABLE_SIZE - 1 || key_tab[slot] != '0) begin
            exp.issue_call = 1'b1;
            exp.call_enable = want;
            exp.status = rtf_pkg::STATUS_FULL;
            n_full++;
         end else begin
            key_tab[slot] = req.cap;
            val_tab[slot] = want;
            fill++;
            exp.issue_call = 1'b1;
            exp.call_enable = want;
         end
      end
      if (exp.issue_call) n_forward++;
      expected_rsp.push_back(exp);
   endfunction

   task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
   endtask

   task check_response(rtf_pkg::rsp_type got);
      rtf_pkg::rsp_type exp;
      if (expected_rsp.size() == 0) begin
         report($sformatf("unexpected response %p", got));
      end else begin
         exp = expected_rsp.pop_front();
         checked++;
         if (got.issue_call !== exp.issue_call)
            report($sformatf("issue_call got %b expected %b", got.issue_call, exp.issue_call));
         if (got.call_enable !== exp.call_enable)
            report($sformatf("call_enable got %b expected %b",
                             got.call_enable, exp.call_enable));
         if (got.status !== exp.status)
            report($sformatf("status got %0d expected %0d", got.status, exp.status));
      end
   endtask

   function int pending();
      return expected_rsp.size();
   endfunction
endclass

module testbench;

   localparam int STALL_LIMIT = 2000;
   localparam int POOL_N = 20;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   rtf_pkg::req_type req_item;
   logic             strobe;
   rtf_pkg::rsp_type rsp_item;

   toggle_filter_model        filt;
   int                        items_sent;
   int                        stall_cycles;
   bit                        no_idle;
   logic [rtf_pkg::KEY_W-1:0] key_pool [POOL_N];

   redundant_toggle_filter_core DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .strobe   (strobe),
      .rsp_item (rsp_item)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) filt.note_request(req_item);
         if (strobe) filt.check_response(rsp_item);
      end
   end

   // watchdog: cycles with no item moving in either direction
   always @(posedge clock) begin
      if (reset || (start && !busy) || strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", stall_cycles);
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   function int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [rtf_pkg::KEY_W-1:0] cap);
      int gap;
      gap = pick_gap();
      req_item <= '{kind: kind, cap: cap};
      start <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // lowers start so the held item is not taken again, then waits out the table
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (filt.pending() != 0) @(posedge clock);
   endtask

   function logic [1:0] rand_kind();
      return 2'($urandom_range(0, 3));
   endfunction

   initial begin
      logic [4:0] low_pick [4];
      logic [rtf_pkg::KEY_W-1:0] k;
      int r;

      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      items_sent = 0;
      no_idle = 1'b0;
      filt = new();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // zero key, every kind
      send_item(rtf_pkg::KIND_ENABLE, 16'h0000);
      send_item(rtf_pkg::KIND_DISABLE, 16'h0000);
      send_item(rtf_pkg::KIND_FORCE_ENABLE, 16'h0000);
      send_item(rtf_pkg::KIND_FORCE_DISABLE, 16'h0000);
      // new key, then redundant and changing requests
      send_item(rtf_pkg::KIND_ENABLE, 16'h0001);
      send_item(rtf_pkg::KIND_ENABLE, 16'h0001);
      send_item(rtf_pkg::KIND_DISABLE, 16'h0001);
      send_item(rtf_pkg::KIND_DISABLE, 16'h0001);
      send_item(rtf_pkg::KIND_FORCE_DISABLE, 16'h0001);
      send_item(rtf_pkg::KIND_FORCE_ENABLE, 16'h0001);
      send_item(rtf_pkg::KIND_ENABLE, 16'h0001);
      // keys on the last slot: probing wraps to slot 0
      send_item(rtf_pkg::KIND_ENABLE, 16'hFFFF);
      send_item(rtf_pkg::KIND_ENABLE, 16'h001F);
      send_item(rtf_pkg::KIND_DISABLE, 16'h003F);
      send_item(rtf_pkg::KIND_DISABLE, 16'h003F);
      send_item(rtf_pkg::KIND_ENABLE, 16'h003F);
      send_item(rtf_pkg::KIND_FORCE_DISABLE, 16'hFFFF);
      send_item(rtf_pkg::KIND_FORCE_ENABLE, 16'h8000);
      send_item(rtf_pkg::KIND_DISABLE, 16'h8000);
      send_item(rtf_pkg::KIND_DISABLE, 16'h7FFF);
      drain();

      // collision-heavy pool: homes at slots 31, 0, 1 and 4 form one cluster
      low_pick[0] = 5'd31;
      low_pick[1] = 5'd0;
      low_pick[2] = 5'd8;
      low_pick[3] = 5'd1;
      foreach (key_pool[i]) begin
         k = {11'($urandom), low_pick[$urandom_range(0, 3)]};
         if (k == '0) k = 16'h0020;
         key_pool[i] = k;
      end

      // pool keys while the table still has room
      for (int n = 0; n < 250; n++) begin
         no_idle = (n >= 100 && n < 150);
         r = $urandom_range(0, 99);
         if (r < 5) send_item(rand_kind(), 16'h0000);
         else send_item(rand_kind(), key_pool[$urandom_range(0, POOL_N - 1)]);
      end
      no_idle = 1'b0;
      drain();

      // wide keys fill the table up to its limit
      for (int n = 0; n < 100; n++) begin
         r = $urandom_range(0, 99);
         if (r < 70) send_item(rand_kind(), 16'($urandom));
         else send_item(rand_kind(), key_pool[$urandom_range(0, POOL_N - 1)]);
      end
      drain();

      // full table: known keys still filter, new ones report full
      for (int n = 0; n < 250; n++) begin
         no_idle = (n >= 150 && n < 200);
         r = $urandom_range(0, 99);
         if (r < 50) send_item(rand_kind(), key_pool[$urandom_range(0, POOL_N - 1)]);
         else if (r < 90) send_item(rand_kind(), 16'($urandom));
         else if (r < 95) send_item(rand_kind(), 16'h0000);
         else send_item(rand_kind(), 16'hFFFF);
      end
      no_idle = 1'b0;

      drain();
      repeat (rtf_pkg::TABLE_SIZE + 4) @(posedge clock);

      if (filt.pending() != 0)
         filt.report($sformatf("%0d responses never arrived", filt.pending()));

      $display("%0d items sent, %0d responses checked, table holds %0d keys",
               items_sent, filt.checked, filt.fill);
      $display("forwarded %0d, dropped as redundant %0d, table full %0d, zero key %0d",
               filt.n_forward, filt.n_redundant, filt.n_full, filt.n_zero);
      if (filt.errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
